/* hdl/mi4_pkg.sv */
// mi4_pkg: shared types and constants for the 4x4 matrix inverse block.
// No dependencies; used by mi4_front, mi4_back and the top level.
package mi4_pkg;

    // Matrix slot queue status, front -> back
    typedef struct packed {
        logic ready;   // a loaded matrix is waiting
        logic slot;    // slot that holds the oldest loaded matrix
    } t_queue_status;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ADDR,
        S_MUL,
        S_ACC,
        S_FREE,
        S_DADDR,
        S_DLOAD,
        S_DIV,
        S_DOUT
    } t_state;

    // Source of the second multiplier operand
    typedef enum logic [1:0] {
        B_ELEM,
        B_MINOR,
        B_COF
    } t_bsel;

    // Accumulate operation applied to the registered product
    typedef enum logic [2:0] {
        OP_T_SET,
        OP_T_SUB,
        OP_D_SET,
        OP_D_SUB,
        OP_D_ADD,
        OP_DET_ADD
    } t_op;

    // One step of the cofactor microprogram; row/col refer to the 3x3 minor
    typedef struct packed {
        logic [1:0] a_n;
        logic [1:0] a_k;
        logic [1:0] b_n;
        logic [1:0] b_k;
        t_bsel      b_sel;
        t_op        op;
    } t_ustep;

    localparam logic [3:0]  LAST_STEP   = 4'd9;
    localparam logic [3:0]  LAST_INDEX  = 4'd15;
    localparam int          OUT_FRAC    = 16;
    localparam logic [31:0] ONE_Q16     = 32'h0001_0000;
    localparam logic [31:0] SAT_POS     = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG     = 32'h8000_0000;

endpackage

/* hdl/matrix4_inverse_adjugate.sv */
// matrix4_inverse_adjugate: top level of the 4x4 adjugate matrix inverter.
// Depends on mi4_pkg, mi4_ram, mi4_front and mi4_back.
//
// Push sixteen signed Q8.8 elements in storage order (row-major); after the
// sixteenth, sixteen signed Q16.16 results come out in the same order, the
// last one flagged by o_last. A zero determinant gives the identity with
// o_singular set; otherwise each result is the adjugate entry over the
// determinant, truncated toward zero and saturated to 32 bits. The front
// loader writes into a two-slot matrix queue held in RAM, so the next
// matrix can be loaded while the current one is worked on; full rises only
// when both slots hold matrices. The back end runs one shared multiplier:
// each cofactor takes nine multiply steps of address, multiply and
// accumulate, plus a determinant step on the first column. Each result
// then goes through a bit-serial restoring divider (32 quotient bits),
// skipped when the matrix is singular or the quotient overflows. A result
// waits in the output register until popped; only the next division stalls
// behind it.

module matrix4_inverse_adjugate #(
    parameter int ELEMENT_BITS  = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [ELEMENT_BITS-1:0] i_element,
    output logic                    empty,
    input  logic                    pop,
    output logic [31:0]             o_value,
    output logic                    o_singular,
    output logic                    o_last
);

    mi4_pkg::t_queue_status w_status;
    logic                    w_free;
    logic                    w_we;
    logic [4:0]              w_waddr;
    logic [ELEMENT_BITS-1:0] w_wdata;
    logic [4:0]              w_raddr_a, w_raddr_b;
    logic [ELEMENT_BITS-1:0] w_rdata_a, w_rdata_b;

    // loader and slot queue
    mi4_front #(.ELEMENT_BITS(ELEMENT_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_element (i_element),
        .i_free    (w_free),
        .o_status  (w_status),
        .o_we      (w_we),
        .o_waddr   (w_waddr),
        .o_wdata   (w_wdata)
    );

    // two copies of the matrix slots: one per multiplier operand
    mi4_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(32)) u_mat_a (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rdata_a)
    );

    mi4_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(32)) u_mat_b (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rdata_b)
    );

    // cofactors, determinant, division, result register
    mi4_back #(
        .ELEMENT_BITS  (ELEMENT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_status   (w_status),
        .o_free     (w_free),
        .o_raddr_a  (w_raddr_a),
        .o_raddr_b  (w_raddr_b),
        .i_rdata_a  (w_rdata_a),
        .i_rdata_b  (w_rdata_b),
        .empty      (empty),
        .pop        (pop),
        .o_value    (o_value),
        .o_singular (o_singular),
        .o_last     (o_last)
    );

endmodule

/* hdl/mi4_ram.sv */
// mi4_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module mi4_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/mi4_front.sv */
// mi4_front: element loader and two-slot matrix queue control.
// Depends on mi4_pkg; drives the write side of the matrix RAMs.
module mi4_front #(
    parameter int ELEMENT_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [ELEMENT_BITS-1:0]   i_element,
    input  logic                      i_free,
    output mi4_pkg::t_queue_status    o_status,
    output logic                      o_we,
    output logic [4:0]                o_waddr,
    output logic [ELEMENT_BITS-1:0]   o_wdata
);

    logic [3:0] r_count;
    logic       r_wslot;
    logic       r_rslot;
    logic [1:0] r_used;
    logic       w_take;
    logic       w_done;

    assign full   = (r_used == 2'd2);
    assign w_take = push && !full;
    assign w_done = w_take && (r_count == mi4_pkg::LAST_INDEX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wslot <= 1'b0;
            r_rslot <= 1'b0;
            r_used  <= '0;
        end else begin
            if (w_take) begin
                r_count <= r_count + 4'd1;
            end
            if (w_done) begin
                r_wslot <= ~r_wslot;
            end
            if (i_free) begin
                r_rslot <= ~r_rslot;
            end
            case ({w_done, i_free})
                2'b10:   r_used <= r_used + 2'd1;
                2'b01:   r_used <= r_used - 2'd1;
                default: r_used <= r_used;
            endcase
        end
    end

    assign o_status.ready = (r_used != 2'd0);
    assign o_status.slot  = r_rslot;
    assign o_we    = w_take;
    assign o_waddr = {r_wslot, r_count};
    assign o_wdata = i_element;

endmodule

/* hdl/mi4_back.sv */
// mi4_back: cofactor/determinant sequencer, restoring divider and result register.
// Depends on mi4_pkg and mi4_ram (cofactor store).
module mi4_back #(
    parameter int ELEMENT_BITS  = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  mi4_pkg::t_queue_status   i_status,
    output logic                     o_free,
    output logic [4:0]               o_raddr_a,
    output logic [4:0]               o_raddr_b,
    input  logic [ELEMENT_BITS-1:0]  i_rdata_a,
    input  logic [ELEMENT_BITS-1:0]  i_rdata_b,
    output logic                     empty,
    input  logic                     pop,
    output logic [31:0]              o_value,
    output logic                     o_singular,
    output logic                     o_last
);

    localparam int E    = ELEMENT_BITS;
    localparam int TW   = 2 * E + 1;        // 2x2 minor
    localparam int CW   = 3 * E + 3;        // cofactor
    localparam int PW   = 4 * E + 3;        // product
    localparam int DETW = 4 * E + 5;        // determinant
    localparam int SHW  = FRACTION_BITS + mi4_pkg::OUT_FRAC;
    localparam int NUMW = CW + SHW;

    mi4_pkg::t_state r_state, n_state;

    logic [1:0]  r_r, r_c;
    logic [3:0]  r_step;
    logic        r_slot;
    logic signed [PW-1:0]   r_prod;
    logic signed [TW-1:0]   r_t;
    logic signed [CW-1:0]   r_d;
    logic signed [DETW-1:0] r_det;
    logic [DETW-1:0]        r_dv;
    logic        r_det_neg, r_det_zero;
    logic [3:0]  r_s;
    logic [DETW-1:0] r_rem;
    logic [31:0] r_lo, r_q;
    logic [4:0]  r_bit;
    logic        r_neg, r_ovf;
    logic        r_ovalid, r_singular, r_last;
    logic [31:0] r_value;

    mi4_pkg::t_ustep w_u;
    logic [1:0]  w_row_a, w_col_a, w_row_b, w_col_b;
    logic signed [E-1:0]  w_a;
    logic signed [CW-1:0] w_b;
    logic signed [PW-1:0] w_prod;
    logic signed [CW-1:0] w_cof;
    logic        w_cof_we;
    logic        w_last_cof;
    logic        w_skip;
    logic [CW-1:0] w_cof_rd;
    logic        w_cof_neg;
    logic [CW-1:0] w_cof_abs;
    logic [NUMW-1:0] w_num;
    logic        w_ovf;
    logic [DETW:0] w_rem_sh;
    logic        w_ge;
    logic        w_out_free;
    logic [31:0] w_result;

    function automatic mi4_pkg::t_ustep f_ustep(input logic [3:0] step);
        mi4_pkg::t_ustep u;
        u = '{a_n: 2'd1, a_k: 2'd1, b_n: 2'd2, b_k: 2'd2,
              b_sel: mi4_pkg::B_ELEM, op: mi4_pkg::OP_T_SET};
        case (step)
            4'd0: u = '{2'd1, 2'd1, 2'd2, 2'd2, mi4_pkg::B_ELEM,  mi4_pkg::OP_T_SET};
            4'd1: u = '{2'd1, 2'd2, 2'd2, 2'd1, mi4_pkg::B_ELEM,  mi4_pkg::OP_T_SUB};
            4'd2: u = '{2'd0, 2'd0, 2'd0, 2'd0, mi4_pkg::B_MINOR, mi4_pkg::OP_D_SET};
            4'd3: u = '{2'd1, 2'd0, 2'd2, 2'd2, mi4_pkg::B_ELEM,  mi4_pkg::OP_T_SET};
            4'd4: u = '{2'd1, 2'd2, 2'd2, 2'd0, mi4_pkg::B_ELEM,  mi4_pkg::OP_T_SUB};
            4'd5: u = '{2'd0, 2'd1, 2'd0, 2'd0, mi4_pkg::B_MINOR, mi4_pkg::OP_D_SUB};
            4'd6: u = '{2'd1, 2'd0, 2'd2, 2'd1, mi4_pkg::B_ELEM,  mi4_pkg::OP_T_SET};
            4'd7: u = '{2'd1, 2'd1, 2'd2, 2'd0, mi4_pkg::B_ELEM,  mi4_pkg::OP_T_SUB};
            4'd8: u = '{2'd0, 2'd2, 2'd0, 2'd0, mi4_pkg::B_MINOR, mi4_pkg::OP_D_ADD};
            4'd9: u = '{2'd0, 2'd0, 2'd0, 2'd0, mi4_pkg::B_COF,   mi4_pkg::OP_DET_ADD};
            default: u = '{2'd0, 2'd0, 2'd0, 2'd0, mi4_pkg::B_COF, mi4_pkg::OP_DET_ADD};
        endcase
        return u;
    endfunction

    // minor index n -> full index, skipping the deleted row/column
    function automatic logic [1:0] f_skip(input logic [1:0] n, input logic [1:0] del);
        return (n < del) ? n : n + 2'd1;
    endfunction

    assign w_u        = f_ustep(r_step);
    assign w_last_cof = (r_r == 2'd3) && (r_c == 2'd3);
    assign w_skip     = (w_u.op == mi4_pkg::OP_DET_ADD) && (r_c != 2'd0);

    always_comb begin
        if (w_u.op == mi4_pkg::OP_DET_ADD) begin
            w_row_a = r_r;
            w_col_a = 2'd0;
        end else begin
            w_row_a = f_skip(w_u.a_n, r_r);
            w_col_a = f_skip(w_u.a_k, r_c);
        end
        w_row_b = f_skip(w_u.b_n, r_r);
        w_col_b = f_skip(w_u.b_k, r_c);
    end

    assign w_cof = (r_r[0] ^ r_c[0]) ? -r_d : r_d;
    assign w_a   = $signed(i_rdata_a);

    always_comb begin
        case (w_u.b_sel)
            mi4_pkg::B_ELEM:  w_b = CW'($signed(i_rdata_b));
            mi4_pkg::B_MINOR: w_b = CW'(r_t);
            mi4_pkg::B_COF:   w_b = w_cof;
            default:          w_b = w_cof;
        endcase
    end

    assign w_prod = PW'(w_a) * PW'(w_b);

    // cofactor store, written in storage order r*4+c, read transposed
    mi4_ram #(.WIDTH(CW), .DEPTH(16)) u_cof_ram (
        .i_clk   (i_clk),
        .i_we    (w_cof_we),
        .i_waddr ({r_r, r_c}),
        .i_wdata (w_cof),
        .i_raddr ({r_s[1:0], r_s[3:2]}),
        .o_rdata (w_cof_rd)
    );

    // divider front: |cof| << (F+16), overflow when the high part reaches |det|
    assign w_cof_neg = w_cof_rd[CW-1];
    assign w_cof_abs = w_cof_neg ? (~w_cof_rd + CW'(1)) : w_cof_rd;
    assign w_num     = {w_cof_abs, SHW'(0)};
    assign w_ovf     = DETW'(w_num[NUMW-1:32]) >= r_dv;
    assign w_rem_sh  = {r_rem, r_lo[31]};
    assign w_ge      = w_rem_sh >= {1'b0, r_dv};

    always_comb begin
        if (r_det_zero) begin
            w_result = (r_s[3:2] == r_s[1:0]) ? mi4_pkg::ONE_Q16 : 32'd0;
        end else if (r_ovf) begin
            w_result = r_neg ? mi4_pkg::SAT_NEG : mi4_pkg::SAT_POS;
        end else if (r_neg) begin
            w_result = (r_q > mi4_pkg::SAT_NEG) ? mi4_pkg::SAT_NEG : (32'd0 - r_q);
        end else begin
            w_result = r_q[31] ? mi4_pkg::SAT_POS : r_q;
        end
    end

    assign w_out_free = !r_ovalid || pop;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mi4_pkg::S_IDLE:  if (i_status.ready) n_state = mi4_pkg::S_ADDR;
            mi4_pkg::S_ADDR: begin
                if (w_skip) begin
                    n_state = w_last_cof ? mi4_pkg::S_FREE : mi4_pkg::S_ADDR;
                end else begin
                    n_state = mi4_pkg::S_MUL;
                end
            end
            mi4_pkg::S_MUL:   n_state = mi4_pkg::S_ACC;
            mi4_pkg::S_ACC: begin
                if (w_u.op == mi4_pkg::OP_DET_ADD && w_last_cof) begin
                    n_state = mi4_pkg::S_FREE;
                end else begin
                    n_state = mi4_pkg::S_ADDR;
                end
            end
            mi4_pkg::S_FREE:  n_state = mi4_pkg::S_DADDR;
            mi4_pkg::S_DADDR: n_state = mi4_pkg::S_DLOAD;
            mi4_pkg::S_DLOAD: begin
                n_state = (r_det_zero || w_ovf) ? mi4_pkg::S_DOUT : mi4_pkg::S_DIV;
            end
            mi4_pkg::S_DIV:   if (r_bit == 5'd0) n_state = mi4_pkg::S_DOUT;
            mi4_pkg::S_DOUT: begin
                if (w_out_free) begin
                    n_state = (r_s == mi4_pkg::LAST_INDEX) ? mi4_pkg::S_IDLE
                                                           : mi4_pkg::S_DADDR;
                end
            end
            default:          n_state = mi4_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_free    = 1'b0;
        w_cof_we  = 1'b0;
        o_raddr_a = {r_slot, w_row_a, w_col_a};
        o_raddr_b = {r_slot, w_row_b, w_col_b};
        case (r_state)
            mi4_pkg::S_ADDR: w_cof_we = (w_u.op == mi4_pkg::OP_DET_ADD);
            mi4_pkg::S_FREE: o_free   = 1'b1;
            default: begin
                o_free   = 1'b0;
                w_cof_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mi4_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            mi4_pkg::S_IDLE: begin
                r_r    <= '0;
                r_c    <= '0;
                r_step <= '0;
                r_det  <= '0;
                r_slot <= i_status.slot;
            end
            mi4_pkg::S_ADDR: begin
                if (w_skip) begin
                    r_step     <= '0;
                    {r_r, r_c} <= {r_r, r_c} + 4'd1;
                end
            end
            mi4_pkg::S_MUL: r_prod <= w_prod;
            mi4_pkg::S_ACC: begin
                case (w_u.op)
                    mi4_pkg::OP_T_SET:   r_t   <= TW'(r_prod);
                    mi4_pkg::OP_T_SUB:   r_t   <= r_t - TW'(r_prod);
                    mi4_pkg::OP_D_SET:   r_d   <= CW'(r_prod);
                    mi4_pkg::OP_D_SUB:   r_d   <= r_d - CW'(r_prod);
                    mi4_pkg::OP_D_ADD:   r_d   <= r_d + CW'(r_prod);
                    mi4_pkg::OP_DET_ADD: r_det <= r_det + DETW'(r_prod);
                    default:             r_t   <= r_t;
                endcase
                if (r_step == mi4_pkg::LAST_STEP) begin
                    r_step     <= '0;
                    {r_r, r_c} <= {r_r, r_c} + 4'd1;
                end else begin
                    r_step <= r_step + 4'd1;
                end
            end
            mi4_pkg::S_FREE: begin
                r_dv       <= r_det[DETW-1] ? DETW'(-r_det) : DETW'(r_det);
                r_det_neg  <= r_det[DETW-1];
                r_det_zero <= (r_det == '0);
                r_s        <= '0;
            end
            mi4_pkg::S_DLOAD: begin
                r_neg <= w_cof_neg ^ r_det_neg;
                r_ovf <= w_ovf;
                r_rem <= DETW'(w_num[NUMW-1:32]);
                r_lo  <= w_num[31:0];
                r_q   <= '0;
                r_bit <= 5'd31;
            end
            mi4_pkg::S_DIV: begin
                r_rem <= w_ge ? DETW'(w_rem_sh - {1'b0, r_dv}) : DETW'(w_rem_sh);
                r_lo  <= {r_lo[30:0], 1'b0};
                r_q   <= {r_q[30:0], w_ge};
                r_bit <= r_bit - 5'd1;
            end
            mi4_pkg::S_DOUT: begin
                if (w_out_free) begin
                    r_s <= r_s + 4'd1;
                end
            end
            default: r_s <= r_s;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == mi4_pkg::S_DOUT && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (pop) begin
            r_ovalid <= 1'b0;
        end
        if (r_state == mi4_pkg::S_DOUT && w_out_free) begin
            r_value    <= w_result;
            r_singular <= r_det_zero;
            r_last     <= (r_s == mi4_pkg::LAST_INDEX);
        end
    end

    assign empty      = !r_ovalid;
    assign o_value    = r_value;
    assign o_singular = r_singular;
    assign o_last     = r_last;

endmodule

/* test/mi4_checker.sv */
// mi4_checker: predicts and checks the results of matrix4_inverse_adjugate.
// Depends on nothing but the port signals of the block; watches both channels.
`timescale 1ns / 1ps

module mi4_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [15:0] i_element,
    input  logic        empty,
    input  logic        pop,
    input  logic [31:0] o_value,
    input  logic        o_singular,
    input  logic        o_last,
    output int          o_errors,
    output int          o_pending
);

    typedef logic signed [127:0] t_wide;
    typedef struct {
        logic [31:0] value;
        logic        singular;
        logic        last;
    } t_inv_elem;

    t_inv_elem  inverse_q[$];
    logic [15:0] loaded[16];
    int          load_idx;

    // Signed 3x3 cofactor of a[r][c]
    function automatic t_wide cofactor_of(t_wide a[4][4], int r, int c);
        t_wide m[3][3];
        t_wide d;
        int rr;
        int cc;
        rr = 0;
        for (int i = 0; i < 4; i++) begin
            if (i != r) begin
                cc = 0;
                for (int j = 0; j < 4; j++) begin
                    if (j != c) begin
                        m[rr][cc] = a[i][j];
                        cc++;
                    end
                end
                rr++;
            end
        end
        d = m[0][0] * (m[1][1] * m[2][2] - m[1][2] * m[2][1])
          - m[0][1] * (m[1][0] * m[2][2] - m[1][2] * m[2][0])
          + m[0][2] * (m[1][0] * m[2][1] - m[1][1] * m[2][0]);
        return ((r + c) % 2 == 1) ? -d : d;
    endfunction

    // Quotient truncated toward zero, saturated to 32 bits
    function automatic logic [31:0] div_sat(t_wide num, t_wide den);
        logic [127:0] an;
        logic [127:0] ad;
        logic [127:0] q;
        logic         neg;
        neg = (num < 0) != (den < 0);
        an  = (num < 0) ? -num : num;
        ad  = (den < 0) ? -den : den;
        q   = an / ad;
        if (neg) return (q >= 128'h8000_0000) ? 32'h8000_0000 : -q[31:0];
        return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    task automatic predict_inverse();
        t_wide     a[4][4];
        t_wide     cof[4][4];
        t_wide     det;
        t_inv_elem e;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                a[i][j] = t_wide'($signed(loaded[i * 4 + j]));
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                cof[i][j] = cofactor_of(a, i, j);
        det = 0;
        for (int i = 0; i < 4; i++) det += a[i][0] * cof[i][0];
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                e.singular = (det == 0);
                e.last     = (i == 3) && (j == 3);
                if (det == 0) e.value = (i == j) ? 32'h0001_0000 : 32'h0;
                else          e.value = div_sat(cof[j][i] <<< 24, det);
                inverse_q.push_back(e);
            end
        end
    endtask

    assign o_pending = inverse_q.size();

    initial begin
        o_errors = 0;
        load_idx = 0;
    end

    always @(posedge i_clk) begin
        t_inv_elem exp_e;
        if (i_rst_n && push && !full) begin
            loaded[load_idx] = i_element;
            if (load_idx == 15) begin
                load_idx = 0;
                predict_inverse();
            end else begin
                load_idx++;
            end
        end
        if (i_rst_n && pop && !empty) begin
            if (inverse_q.size() == 0) begin
                o_errors++;
                if (o_errors <= 10)
                    $display("unexpected result transfer: value %h", o_value);
            end else begin
                exp_e = inverse_q.pop_front();
                if (o_value !== exp_e.value || o_singular !== exp_e.singular
                        || o_last !== exp_e.last) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("mismatch: exp value %h sing %b last %b, got %h %b %b",
                                 exp_e.value, exp_e.singular, exp_e.last,
                                 o_value, o_singular, o_last);
                end
            end
        end
    end

endmodule

/* test/tb_matrix4_inverse_adjugate.sv */
// tb_matrix4_inverse_adjugate: stimulus and verdict for the matrix inverter.
// Depends on matrix4_inverse_adjugate (and its package) and mi4_checker.
`timescale 1ns / 1ps

module tb_matrix4_inverse_adjugate;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [15:0] i_element;
    logic        empty;
    logic        pop;
    logic [31:0] o_value;
    logic        o_singular;
    logic        o_last;
    int          n_errors;
    int          n_pending;
    logic        sink_hold;   // receiver holds off for a long stretch

    matrix4_inverse_adjugate u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_element  (i_element),
        .empty      (empty),
        .pop        (pop),
        .o_value    (o_value),
        .o_singular (o_singular),
        .o_last     (o_last)
    );

    mi4_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_element  (i_element),
        .empty      (empty),
        .pop        (pop),
        .o_value    (o_value),
        .o_singular (o_singular),
        .o_last     (o_last),
        .o_errors   (n_errors),
        .o_pending  (n_pending)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(20, 80);
    endfunction

    // One element transfer; push stays high into the next item when no gap follows
    task automatic send_element(logic [15:0] v);
        int g;
        push      = 1'b1;
        i_element = v;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        g = gap_len();
        if (g > 0) begin
            push      = 1'b0;
            i_element = 16'($urandom);
            repeat (g) @(negedge i_clk);
        end
    endtask

    task automatic send_matrix(logic [15:0] m[16]);
        for (int k = 0; k < 16; k++) send_element(m[k]);
    endtask

    // Random element: full range, extremes, or small magnitudes
    function automatic logic [15:0] rand_element(int style);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h7FFF;
        if (r == 1) return 16'h8000;
        if (style == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 1024)) - 512);
    endfunction

    // Receiver: random pop gaps; sink_hold forces a long stall
    initial begin
        int g;
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (sink_hold) begin
                pop = 1'b0;
            end else begin
                g = gap_len();
                if (g == 0) begin
                    pop = 1'b1;
                end else begin
                    pop = 1'b0;
                    repeat (g - 1) @(negedge i_clk);
                end
            end
        end
    end

    // Long receiver hold-off at the start so both matrix slots fill
    initial begin
        sink_hold = 1'b1;
        @(posedge i_rst_n);
        repeat (4000) @(posedge i_clk);
        @(negedge i_clk);
        sink_hold = 1'b0;
    end

    initial begin
        logic [15:0] m[16];
        int          style;
        push      = 1'b0;
        i_element = '0;
        i_rst_n   = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Identity in Q8.8
        for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 16'h0100 : 16'h0000;
        send_matrix(m);
        // Tiny determinant with large cofactors: saturates both ways
        for (int k = 0; k < 16; k++) m[k] = 16'h0000;
        m[0] = 16'd2;  m[1] = 16'd181; m[4] = 16'hFF4B; m[5] = 16'd16381;
        m[10] = 16'h0100; m[15] = 16'h0100;
        m[4] = 16'd181;
        send_matrix(m);
        m[1] = 16'hFF4B; m[4] = 16'hFF4B;
        send_matrix(m);

        // Random matrices; some with repeated rows or columns or all-zero to go singular
        for (int n = 0; n < 26; n++) begin
            style = $urandom_range(0, 1);
            for (int k = 0; k < 16; k++) m[k] = rand_element(style);
            case ($urandom_range(0, 5))
                0: for (int k = 0; k < 4; k++) m[8 + k] = m[k];
                1: for (int k = 0; k < 16; k++) m[k] = 16'h0000;
                2: for (int k = 0; k < 4; k++) m[4 * k + 3] = m[4 * k];
                default: ;
            endcase
            send_matrix(m);
        end
        push = 1'b0;

        wait (n_pending == 0);
        repeat (200) @(posedge i_clk);
        if (n_errors == 0 && n_pending == 0) begin
            $display("matrix4_inverse_adjugate regression: pass");
        end else begin
            $display("matrix4_inverse_adjugate regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #6000000;
        $display("matrix4_inverse_adjugate regression: fail");
        $finish;
    end

endmodule
